// ----- design/fmeg_pkg.sv -----
// Shared types, constants and the attack curve of the FM envelope generator.
package fmeg_pkg;

  localparam int unsigned NumSlotsDef = 18;

  localparam int unsigned PhaseW = 23;
  localparam int unsigned LfsrW  = 18;
  localparam int unsigned AmW    = 20;
  localparam int unsigned AttnW  = 7;

  localparam logic [LfsrW-1:0]  LfsrReset    = 18'h3ffff;
  localparam logic [PhaseW-1:0] PhaseAllOnes = 23'h7fffff;
  localparam logic [PhaseW-1:0] PhaseAttack  = 23'h3fffff;
  localparam logic [AttnW-1:0]  AttnMax      = 7'h7f;
  localparam logic [4:0]        AmWrapTop    = 5'h1f;
  localparam logic [3:0]        RhythmPair   = 4'd7;
  localparam logic [4:0]        ReleaseEnd   = 5'd15;
  localparam logic [3:0]        RateMax      = 4'd15;

  typedef enum logic [1:0] {
    MODE_ATTACK  = 2'd0,
    MODE_DECAY   = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_FINISH  = 2'd3
  } env_mode_e;

  // One input transaction
  typedef struct packed {
    logic [4:0] slot_index;
    logic [6:0] total_level;
    logic [3:0] key_scale_rate;
    logic [3:0] release_rate;
    logic [3:0] attack_rate;
    logic [3:0] decay_rate;
    logic [3:0] sustain_level;
    logic       am_enable;
    logic       key_on;
    logic       rhythm_on;
  } in_item_t;

  // One result transaction
  typedef struct packed {
    logic [AttnW-1:0] attenuation;
  } out_item_t;

  // Per-slot state; only the low three bits of the step are ever read back
  typedef struct packed {
    env_mode_e         mode;
    logic [PhaseW-1:0] phase;
    logic [2:0]        step_lo;
    logic              prev_key;
  } slot_state_t;

  localparam logic [6:0] AtkCurve [128] = '{
    7'd127, 7'd127, 7'd108, 7'd98, 7'd90, 7'd84, 7'd80, 7'd75,
    7'd72, 7'd69, 7'd66, 7'd64, 7'd61, 7'd59, 7'd57, 7'd56,
    7'd54, 7'd52, 7'd51, 7'd49, 7'd48, 7'd47, 7'd45, 7'd44,
    7'd43, 7'd42, 7'd41, 7'd40, 7'd39, 7'd38, 7'd37, 7'd36,
    7'd36, 7'd35, 7'd34, 7'd33, 7'd33, 7'd32, 7'd31, 7'd30,
    7'd30, 7'd29, 7'd29, 7'd28, 7'd27, 7'd27, 7'd26, 7'd26,
    7'd25, 7'd24, 7'd24, 7'd23, 7'd23, 7'd22, 7'd22, 7'd21,
    7'd21, 7'd21, 7'd20, 7'd20, 7'd19, 7'd19, 7'd18, 7'd18,
    7'd17, 7'd17, 7'd17, 7'd16, 7'd16, 7'd15, 7'd15, 7'd15,
    7'd14, 7'd14, 7'd14, 7'd13, 7'd13, 7'd13, 7'd12, 7'd12,
    7'd12, 7'd11, 7'd11, 7'd11, 7'd10, 7'd10, 7'd10, 7'd9,
    7'd9, 7'd9, 7'd9, 7'd8, 7'd8, 7'd8, 7'd7, 7'd7,
    7'd7, 7'd7, 7'd6, 7'd6, 7'd6, 7'd6, 7'd5, 7'd5,
    7'd5, 7'd4, 7'd4, 7'd4, 7'd4, 7'd4, 7'd3, 7'd3,
    7'd3, 7'd3, 7'd2, 7'd2, 7'd2, 7'd2, 7'd1, 7'd1,
    7'd1, 7'd1, 7'd1, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0
  };

endpackage

// ----- design/fmeg_stream_if.sv -----
// Valid/ready stream interface carrying one payload struct per transaction.
interface fmeg_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/fm_envelope_generator_unit.sv -----
// Top level of the time-multiplexed FM operator envelope generator.
//
// Usage: one input transaction per operator slot time on in_i carries the
// slot index and that slot's rate, level and key settings. Every transaction
// yields exactly one result transaction on out_o with the 7-bit attenuation.
// The shared noise LFSR and AM-LFO counter step once per transaction, also for
// a slot index beyond the last slot (which reads 127 and changes no slot).
// Path: a transaction lands in the input register, and its result then moves
// into the output register, which drives out_o.valid; a stall on out_o holds
// it in the input register meanwhile. Throughput: one transaction per cycle
// while out_o.ready is high; per-slot state is read and written in the same
// cycle, so consecutive steps of one slot see each other's update, no bubble.
// Reset: every slot goes to finish mode with phase and step zero and key low,
// the LFSR to all ones and the AM counter to zero; both registers empty.
// Stall: while out_o.ready is low the result holds, the pending input
// transaction waits in the input register and in_i.ready drops once it is
// full; nothing is lost or repeated.
module fm_envelope_generator_unit
  import fmeg_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = NumSlotsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  fmeg_stream_if.sink          in_i,
  fmeg_stream_if.source        out_o
);

  localparam int unsigned SlotW = $clog2(NUM_SLOTS);

  in_item_t         in_q;
  logic             in_vld_q;
  out_item_t        out_q;
  logic             out_vld_q;
  logic [LfsrW-1:0] lfsr_q, lfsr_d;
  logic [AmW-1:0]   am_q, am_d, am_inc;
  slot_state_t      slot_q [NUM_SLOTS];
  slot_state_t      cur_state;
  slot_state_t      nxt_state;
  logic [AttnW-1:0] calc_attn;
  logic [SlotW-1:0] slot_idx;
  logic             slot_ok;
  logic             fire;

  // Process the held transaction when the output register is free
  assign fire      = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || fire;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  assign slot_ok   = {1'b0, in_q.slot_index} < 6'(NUM_SLOTS);
  assign slot_idx  = in_q.slot_index[SlotW-1:0];
  assign cur_state = slot_q[slot_idx];

  // Advance shared noise LFSR and AM counter
  always_comb begin
    lfsr_d = {lfsr_q[LfsrW-2:0], lfsr_q[17] ^ lfsr_q[14]};
    am_inc = am_q + 20'd1;
    am_d   = (am_inc[19:15] == AmWrapTop) ? {4'b0, am_inc[15:0]} : am_inc;
  end

  fmeg_env_calc u_calc (
    .item_i   (in_q),
    .state_i  (cur_state),
    .noise_i  (lfsr_d[0]),
    .am_cnt_i (am_d),
    .state_o  (nxt_state),
    .attn_o   (calc_attn)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.attenuation <= slot_ok ? calc_attn : AttnMax;
    end
  end

  // Shared generators and per-slot state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= LfsrReset;
      am_q   <= '0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        slot_q[s].mode     <= MODE_FINISH;
        slot_q[s].phase    <= '0;
        slot_q[s].step_lo  <= '0;
        slot_q[s].prev_key <= 1'b0;
      end
    end else if (fire) begin
      lfsr_q <= lfsr_d;
      am_q   <= am_d;
      if (slot_ok) begin
        slot_q[slot_idx] <= nxt_state;
      end
    end
  end

endmodule

// ----- design/fmeg_env_calc.sv -----
// Attenuation and next slot state for one envelope step.
module fmeg_env_calc
  import fmeg_pkg::*;
(
  input  in_item_t         item_i,
  input  slot_state_t      state_i,
  input  logic             noise_i,
  input  logic [AmW-1:0]   am_cnt_i,
  output slot_state_t      state_o,
  output logic [AttnW-1:0] attn_o
);

  logic [8:0]        sum;
  logic [3:0]        am_add;
  logic [3:0]        rate;
  logic [4:0]        rate_sum;
  logic [3:0]        rate_eff;
  logic [PhaseW-1:0] atk_step;
  logic [PhaseW-1:0] dr_step;
  logic [2:0]        dr_base;
  logic [5:0]        atk_base;
  logic [PhaseW-1:0] phase_adv;
  logic [2:0]        step_nxt;
  env_mode_e         mode_nxt;
  logic [PhaseW-1:0] phase_nxt;

  // Form the attenuation sum from mode, noise and AM triangle
  always_comb begin
    unique case (state_i.mode)
      MODE_ATTACK: begin
        rate = item_i.attack_rate;
        sum  = {2'b0, item_i.total_level} + {2'b0, AtkCurve[~state_i.phase[21:15]]};
      end
      MODE_DECAY: begin
        rate = item_i.decay_rate;
        sum  = {2'b0, item_i.total_level} + {2'b0, state_i.phase[21:15]};
      end
      MODE_RELEASE: begin
        rate = item_i.release_rate;
        sum  = {2'b0, item_i.total_level} + {2'b0, state_i.phase[21:15]};
      end
      default: begin
        rate = '0;
        sum  = {2'b0, AttnMax};
      end
    endcase
    if (noise_i && (item_i.slot_index[4:1] == RhythmPair) && item_i.rhythm_on) begin
      sum = sum + 9'h080;
    end
    am_add = am_cnt_i[19] ? ~am_cnt_i[18:15] : (am_cnt_i[18:15] - 4'd1);
    if (item_i.am_enable) begin
      sum = sum + {5'b0, am_add};
    end
    attn_o = sum[8:7] != 2'b0 ? AttnMax : sum[6:0];
  end

  // Scale the rate and build both step candidates
  always_comb begin
    rate_sum = {1'b0, rate} + {3'b0, item_i.key_scale_rate[3:2]};
    rate_eff = rate_sum[4] ? RateMax : rate_sum[3:0];
    atk_base = 6'd6 * {3'b0, 3'd4 + {1'b0, item_i.key_scale_rate[1:0]}};
    atk_step = {{(PhaseW-6){1'b0}}, atk_base} << rate_eff;
    dr_base  = state_i.step_lo | (3'd4 + {1'b0, item_i.key_scale_rate[1:0]});
    dr_step  = {{(PhaseW-3){1'b0}}, dr_base} << (rate_eff - 4'd1);
  end

  // Advance the phase and step, then the mode transitions and key edges
  always_comb begin
    phase_adv = state_i.phase;
    step_nxt  = state_i.step_lo;
    if (rate != 4'd0) begin
      if (state_i.mode == MODE_ATTACK) begin
        step_nxt  = atk_step[2:0];
        phase_adv = state_i.phase - atk_step;
      end else if (state_i.mode != MODE_FINISH) begin
        step_nxt  = dr_step[2:0];
        phase_adv = state_i.phase + dr_step;
      end
    end

    mode_nxt  = state_i.mode;
    phase_nxt = phase_adv;
    unique case (state_i.mode)
      MODE_ATTACK: begin
        if (phase_adv[22]) begin
          phase_nxt = '0;
          mode_nxt  = MODE_DECAY;
        end
      end
      MODE_DECAY: begin
        if (phase_adv[22:18] >= {1'b0, item_i.sustain_level}) begin
          mode_nxt = MODE_RELEASE;
        end
      end
      MODE_RELEASE: begin
        if (phase_adv[22:18] >= ReleaseEnd) begin
          mode_nxt = MODE_FINISH;
        end
      end
      default: begin
        phase_nxt = PhaseAllOnes;
      end
    endcase

    if (!state_i.prev_key && item_i.key_on) begin
      phase_nxt = PhaseAttack;
      mode_nxt  = MODE_ATTACK;
    end else if (state_i.prev_key && !item_i.key_on && mode_nxt != MODE_FINISH) begin
      mode_nxt = MODE_RELEASE;
    end

    state_o.mode     = mode_nxt;
    state_o.phase    = phase_nxt;
    state_o.step_lo  = step_nxt;
    state_o.prev_key = item_i.key_on;
  end

endmodule

// ----- tb/fmeg_attn_checker.sv -----
// Attenuation checker: predicts each envelope step and compares the block's results.
module fmeg_attn_checker
  import fmeg_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = NumSlotsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_data_i,
  output int        fail_count_o,
  output int        outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Attack curve, indexed by the inverted level
  localparam int AttackCurve [128] = '{
    127, 127, 108, 98, 90, 84, 80, 75, 72, 69, 66, 64, 61, 59, 57, 56,
    54, 52, 51, 49, 48, 47, 45, 44, 43, 42, 41, 40, 39, 38, 37, 36,
    36, 35, 34, 33, 33, 32, 31, 30, 30, 29, 29, 28, 27, 27, 26, 26,
    25, 24, 24, 23, 23, 22, 22, 21, 21, 21, 20, 20, 19, 19, 18, 18,
    17, 17, 17, 16, 16, 15, 15, 15, 14, 14, 14, 13, 13, 13, 12, 12,
    12, 11, 11, 11, 10, 10, 10, 9, 9, 9, 9, 8, 8, 8, 7, 7,
    7, 7, 6, 6, 6, 6, 5, 5, 5, 4, 4, 4, 4, 4, 3, 3,
    3, 3, 2, 2, 2, 2, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0
  };

  // Shadow copy of the envelope state
  env_mode_e   mode_q    [NUM_SLOTS];
  logic [22:0] phase_q   [NUM_SLOTS];
  logic [2:0]  step_lo_q [NUM_SLOTS];
  logic        key_q     [NUM_SLOTS];
  logic [17:0] noise_q;
  logic [19:0] lfo_q;

  logic [6:0] attn_expected_q [$];
  logic [6:0] want_attn;
  int         mismatch_cnt;

  assign fail_count_o = mismatch_cnt;

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("%0t ns attenuation check: %s (expected %0d, got %0d)",
             $realtime, what, want, got);
    mismatch_cnt++;
  endtask

  // Advance the shared counters and one slot, return the attenuation it shows
  function automatic logic [6:0] step_envelope(input in_item_t it);
    logic [4:0]  slot;
    env_mode_e   md;
    logic [22:0] ph;
    logic [4:0]  tri_v;
    logic [3:0]  tri_lo;
    int unsigned sum;
    int unsigned rate;
    int unsigned st;
    logic [6:0]  attn;
    slot = it.slot_index;
    noise_q = {noise_q[16:0], noise_q[17] ^ noise_q[14]};
    lfo_q = lfo_q + 20'd1;
    if (lfo_q[19:15] == 5'h1f) lfo_q[19:16] = 4'h0;
    if (slot >= NUM_SLOTS) return 7'h7f;

    md = mode_q[slot];
    ph = phase_q[slot];
    rate = 0;
    case (md)
      MODE_ATTACK: begin
        rate = it.attack_rate;
        sum = it.total_level + AttackCurve[~ph[21:15]];
      end
      MODE_DECAY: begin
        rate = it.decay_rate;
        sum = it.total_level + ph[21:15];
      end
      MODE_RELEASE: begin
        rate = it.release_rate;
        sum = it.total_level + ph[21:15];
      end
      default: sum = 127;
    endcase

    // Rhythm noise on the snare/hi-hat pair
    if (noise_q[0] && slot[4:1] == 4'd7 && it.rhythm_on) sum += 128;

    // AM triangle
    if (it.am_enable) begin
      tri_v = lfo_q[19:15];
      if (!lfo_q[19]) begin
        tri_lo = tri_v[3:0] - 4'd1;
        sum += tri_lo;
      end else begin
        sum += 15 - tri_v[3:0];
      end
    end
    attn = (sum < 128) ? sum[6:0] : 7'h7f;

    // Advance the phase by the key-scaled rate
    if (rate != 0) begin
      rate += it.key_scale_rate[3:2];
      if (rate > 15) rate = 15;
      if (md == MODE_ATTACK) begin
        st = (6 * (4 + it.key_scale_rate[1:0])) & 'h3f;
        st = st << rate;
        step_lo_q[slot] = st[2:0];
        ph = ph - st[22:0];
      end else if (md == MODE_DECAY || md == MODE_RELEASE) begin
        st = step_lo_q[slot] | (4 + it.key_scale_rate[1:0]);
        st = st << ((rate - 1) & 'hf);
        step_lo_q[slot] = st[2:0];
        ph = ph + st[22:0];
      end
    end

    // Mode transitions
    case (md)
      MODE_ATTACK: begin
        if (ph[22]) begin
          ph = '0;
          md = MODE_DECAY;
        end
      end
      MODE_DECAY:   if (ph[22:18] >= it.sustain_level) md = MODE_RELEASE;
      MODE_RELEASE: if (ph[22:18] >= 5'd15) md = MODE_FINISH;
      default:      ph = '1;
    endcase

    // Key edges
    if (!key_q[slot] && it.key_on) begin
      ph = 23'h3fffff;
      md = MODE_ATTACK;
    end else if (key_q[slot] && !it.key_on && md != MODE_FINISH) begin
      md = MODE_RELEASE;
    end

    key_q[slot]   = it.key_on;
    mode_q[slot]  = md;
    phase_q[slot] = ph;
    return attn;
  endfunction

  // Predict on accepted steps, compare on accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        mode_q[s]    = MODE_FINISH;
        phase_q[s]   = '0;
        step_lo_q[s] = '0;
        key_q[s]     = 1'b0;
      end
      noise_q = 18'h3ffff;
      lfo_q = '0;
      attn_expected_q.delete();
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (attn_expected_q.size() == 0) begin
          report_mismatch("result with no step pending", -1, out_data_i.attenuation);
        end else begin
          want_attn = attn_expected_q.pop_front();
          if (out_data_i.attenuation !== want_attn)
            report_mismatch("attenuation differs", want_attn, out_data_i.attenuation);
        end
      end
      if (in_valid_i && in_ready_i) attn_expected_q.push_back(step_envelope(in_data_i));
      outstanding_o <= attn_expected_q.size();
    end
  end

  initial mismatch_cnt = 0;

endmodule

// ----- tb/tb_fm_envelope_generator_unit.sv -----
// Testbench top: drives envelope steps into the generator and gives the verdict.
module tb_fm_envelope_generator_unit
  import fmeg_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 1000;
  localparam int RandomSteps = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic quiet = 1'b0;
  int   fail_count;
  int   outstanding;
  int   stall_cycles = 0;

  in_item_t   slot_cfg [NumSlotsDef];
  logic [4:0] hot_slot [4];

  fmeg_stream_if #(.T(in_item_t))  in_if ();
  fmeg_stream_if #(.T(out_item_t)) out_if ();

  fm_envelope_generator_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  fmeg_attn_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_if.valid),
    .in_ready_i    (in_if.ready),
    .in_data_i     (in_if.data),
    .out_valid_i   (out_if.valid),
    .out_ready_i   (out_if.ready),
    .out_data_i    (out_if.data),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly fast rates so envelopes run through all modes
  function automatic logic [3:0] pick_rate();
    if ($urandom_range(0, 3) == 0) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(10, 15));
  endfunction

  function automatic in_item_t rand_profile(input logic key);
    in_item_t p;
    p.slot_index     = '0;
    p.total_level    = $urandom_range(0, 1) ? 7'($urandom_range(0, 31))
                                            : 7'($urandom_range(0, 127));
    p.key_scale_rate = 4'($urandom_range(0, 15));
    p.release_rate   = pick_rate();
    p.attack_rate    = pick_rate();
    p.decay_rate     = pick_rate();
    p.sustain_level  = 4'($urandom_range(0, 15));
    p.am_enable      = 1'($urandom_range(0, 1));
    p.key_on         = key;
    p.rhythm_on      = 1'($urandom_range(0, 1));
    return p;
  endfunction

  function automatic in_item_t make_step(input int slot, input int tl, input int ksr,
                                         input int rr, input int ar, input int dr,
                                         input int sl, input int am, input int key,
                                         input int rhy);
    in_item_t p;
    p.slot_index     = 5'(slot);
    p.total_level    = 7'(tl);
    p.key_scale_rate = 4'(ksr);
    p.release_rate   = 4'(rr);
    p.attack_rate    = 4'(ar);
    p.decay_rate     = 4'(dr);
    p.sustain_level  = 4'(sl);
    p.am_enable      = 1'(am);
    p.key_on         = 1'(key);
    p.rhythm_on      = 1'(rhy);
    return p;
  endfunction

  // Offer one step, with an optional idle burst ahead of it
  task automatic send_step(input in_item_t it);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Hold off the sender until every pending result is back
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Result side: random stall bursts between stretches of readiness
  initial begin
    out_if.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("tb_fm_envelope_generator_unit: errors");
        $finish;
      end
    end
  end

  initial begin
    in_item_t   it;
    logic [63:0] raw;
    int         slot;
    int         pick;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: finish after reset, slots out of range, full envelope on slot 0
    send_step(make_step(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_step(make_step(31, 127, 15, 15, 15, 15, 15, 1, 1, 1));
    send_step(make_step(18, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    repeat (6) send_step(make_step(0, 0, 15, 15, 15, 15, 0, 0, 1, 0));
    send_step(make_step(0, 0, 15, 15, 15, 15, 0, 0, 0, 0));
    send_step(make_step(0, 127, 15, 15, 15, 15, 0, 1, 0, 0));
    // Zero rate holds the phase; high level saturates
    repeat (3) send_step(make_step(1, 127, 0, 0, 0, 0, 15, 1, 1, 0));
    // Rhythm noise on the snare/hi-hat pair
    repeat (2) begin
      send_step(make_step(14, 10, 12, 15, 15, 15, 8, 1, 1, 1));
      send_step(make_step(15, 10, 3, 15, 15, 15, 8, 0, 1, 1));
    end
    send_step(make_step(17, 0, 0, 1, 15, 1, 15, 0, 1, 0));
    send_step(make_step(16, 64, 7, 8, 8, 8, 4, 1, 1, 0));
    send_step(make_step(14, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    drain_results();

    // Random: per-slot profiles, key edges, a few hot slots
    for (int s = 0; s < NumSlotsDef; s++)
      slot_cfg[s] = rand_profile(1'($urandom_range(0, 4) < 3));
    hot_slot[0] = 5'd14;
    hot_slot[1] = 5'd15;
    hot_slot[2] = 5'($urandom_range(0, NumSlotsDef - 1));
    hot_slot[3] = 5'($urandom_range(0, NumSlotsDef - 1));

    for (int n = 0; n < RandomSteps; n++) begin
      if (n == RandomSteps / 2) drain_results();
      if (n == RandomSteps - 60) quiet = 1'b1;
      pick = $urandom_range(0, 99);
      raw = {$urandom(), $urandom()};
      if (pick < 5) begin
        it = raw[$bits(in_item_t)-1:0];
        it.slot_index = 5'($urandom_range(NumSlotsDef, 31));
      end else begin
        slot = (pick < 70) ? hot_slot[$urandom_range(0, 3)]
                           : $urandom_range(0, NumSlotsDef - 1);
        if ($urandom_range(0, 99) < 8) begin
          // Noise: any field values for this slot
          it = raw[$bits(in_item_t)-1:0];
          slot_cfg[slot].key_on = it.key_on;
        end else begin
          if ($urandom_range(0, 99) < 4)
            slot_cfg[slot] = rand_profile(slot_cfg[slot].key_on);
          if ($urandom_range(0, 99) < 5)
            slot_cfg[slot].key_on = !slot_cfg[slot].key_on;
          it = slot_cfg[slot];
        end
        it.slot_index = 5'(slot);
      end
      send_step(it);
    end

    drain_results();
    repeat (6) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_fm_envelope_generator_unit: clean");
    end else begin
      $display("tb_fm_envelope_generator_unit: errors");
    end
    $finish;
  end

endmodule
